/* design/gzosp_pkg.sv */
// Package for the grid 0-1 shortest-path engine: sizes, codes and request types.
package gzosp_pkg;

    localparam int MAX_SIDE    = 64;
    localparam int DEQUE_DEPTH = 8192;
    localparam int SIDE_W      = $clog2(MAX_SIDE);
    localparam int CELLS       = MAX_SIDE * MAX_SIDE;
    localparam int CELL_W      = $clog2(CELLS);
    localparam int DQ_W        = $clog2(DEQUE_DEPTH);
    localparam int DIST_W      = 12;
    localparam int DIST_MAX    = (1 << DIST_W) - 1;
    localparam int QENT_W      = 2 * SIDE_W + DIST_W;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_RUN  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    localparam logic [1:0] KIND_ZERO  = 2'd0;
    localparam logic [1:0] KIND_UNIT  = 2'd1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]        operation;
        logic [SIDE_W-1:0] cell_x;
        logic [SIDE_W-1:0] cell_y;
        logic [1:0]        cell_kind;
    } req_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              reachable;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_POP,
        ST_POPWAIT,
        ST_CHECK,
        ST_NBR,
        ST_NBRWAIT,
        ST_RELAX,
        ST_READWAIT
    } state_t;

    // Clamp a grid size register to 1..MAX_SIDE.
    function automatic logic [SIDE_W:0] eff_size(input logic [6:0] v);
        logic [SIDE_W:0] r;
        if (v == 7'd0) r = (SIDE_W+1)'(1);
        else if (32'(v) > MAX_SIDE) r = (SIDE_W+1)'(MAX_SIDE);
        else r = (SIDE_W+1)'(v);
        return r;
    endfunction

endpackage

/* design/gzosp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module gzosp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/gzosp_deque.sv */
// Double-ended work queue held in one RAM, with head/tail pointers and a count.
module gzosp_deque (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clear,
    input  logic                              put_front,
    input  logic                              put_back,
    input  logic [gzosp_pkg::QENT_W-1:0]      push_data,
    input  logic                              pop,
    output logic [gzosp_pkg::QENT_W-1:0]      head_data,
    output logic                              empty
);
    import gzosp_pkg::*;

    logic [DQ_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [DQ_W:0]   count_reg, count_next;
    logic            full;
    logic            we;
    logic [DQ_W-1:0] waddr;
    logic [DQ_W-1:0] front_slot;
    logic [QENT_W-1:0] ram_rdata;
    logic              fwd_reg;
    logic [QENT_W-1:0] fwd_data_reg;

    assign full       = (32'(count_reg) >= DEQUE_DEPTH);
    assign empty      = (count_reg == '0);
    assign front_slot = (head_reg == '0) ? DQ_W'(DEQUE_DEPTH - 1) : head_reg - 1'b1;
    assign head_data  = fwd_reg ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        we         = 1'b0;
        waddr      = tail_reg;
        if (clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (pop)
        begin
            head_next  = (32'(head_reg) + 1 >= DEQUE_DEPTH) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        else if (put_front && !full)
        begin
            we         = 1'b1;
            waddr      = front_slot;
            head_next  = front_slot;
            count_next = count_reg + 1'b1;
        end
        else if (put_back && !full)
        begin
            we         = 1'b1;
            waddr      = tail_reg;
            tail_next  = (32'(tail_reg) + 1 >= DEQUE_DEPTH) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fwd_reg   <= we && (waddr == head_next);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= push_data;
    end

    // The head entry is read from head_next so it is valid in the cycle after any update.
    // A write into the head slot is forwarded while the RAM still returns the old word.
    gzosp_ram #(.WIDTH(QENT_W), .DEPTH(DEQUE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (push_data),
        .raddr (head_next),
        .rdata (ram_rdata)
    );
endmodule

/* design/grid_zero_one_shortest_path_top.sv */
// Top level: command port, kind and distance memories, and the search sequencer.
// A read keeps busy high for one cycle after it is accepted and strobes its result
// in the cycle after that. A run clears the distance memory, then pops each queue
// entry and checks it against its stored distance, reads and relaxes each in-grid
// neighbor, skips neighbors outside the grid, and ends when the queue is found empty.
// Reset is asynchronous active low; distances read as unreachable until the first run.
module grid_zero_one_shortest_path_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  gzosp_pkg::req_t      request,
    output logic                 busy,
    output logic                 result_valid,
    output gzosp_pkg::rsp_t      result,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [6:0]           cfg_data
);
    import gzosp_pkg::*;

    state_t state_reg, state_next;
    logic [6:0] width_reg, height_reg;
    logic [SIDE_W:0] w_eff, h_eff;

    logic [CELL_W-1:0] clr_reg, clr_next;
    logic [SIDE_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [DIST_W-1:0] cd_reg, cd_next, td_reg, td_next;
    logic [3:0]        nbr_reg, nbr_next;
    logic [SIDE_W-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic [SIDE_W-1:0] rx_reg, ry_reg;
    logic              searched_reg;

    // Memory ports
    logic              k_we;
    logic [CELL_W-1:0] k_waddr, k_raddr;
    logic [1:0]        k_wdata, k_rdata;
    logic              d_we;
    logic [CELL_W-1:0] d_waddr, d_raddr;
    logic [DIST_W:0]   d_wdata, d_rdata;

    logic              q_clear, q_pf, q_pb, q_pop, q_empty;
    logic [QENT_W-1:0] q_head;
    logic              out_valid_next;
    rsp_t              out_next;
    logic              accept;

    assign w_eff  = eff_size(width_reg);
    assign h_eff  = eff_size(height_reg);
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // Neighbor offsets in order dx outer, dy inner, center skipped.
    logic signed [2:0] ndx, ndy;
    logic signed [SIDE_W+1:0] ntx, nty;
    logic              n_in;
    always_comb
    begin
        ndx = 3'(signed'(32'(nbr_reg >= 4'd3) + 32'(nbr_reg >= 4'd5) - 1));
        case (nbr_reg)
            4'd0, 4'd3, 4'd5: ndy = -3'sd1;
            4'd1, 4'd6:       ndy = 3'sd0;
            default:          ndy = 3'sd1;
        endcase
        ntx  = signed'({2'b00, cx_reg}) + (SIDE_W+2)'(ndx);
        nty  = signed'({2'b00, cy_reg}) + (SIDE_W+2)'(ndy);
        n_in = (ntx >= 0) && (nty >= 0) && (ntx < signed'({1'b0, w_eff}))
            && (nty < signed'({1'b0, h_eff}));
    end

    logic [SIDE_W-1:0] hx, hy;
    logic [DIST_W-1:0] hd;
    assign {hx, hy, hd} = q_head;

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        cx_next = cx_reg; cy_next = cy_reg; cd_next = cd_reg; td_next = td_reg;
        nbr_next = nbr_reg; tx_next = tx_reg; ty_next = ty_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                clr_next = '0;
                if (accept)
                begin
                    cx_next = request.cell_x;
                    cy_next = request.cell_y;
                    unique case (op_t'(request.operation))
                        OP_RUN:  state_next = ST_CLEAR;
                        OP_READ: state_next = ST_READWAIT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CELL_W'(CELLS - 1))
                begin
                    state_next = (({1'b0, cx_reg} < w_eff) && ({1'b0, cy_reg} < h_eff))
                        ? ST_POP : ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (!q_empty)
                begin
                    cx_next = hx; cy_next = hy; cd_next = hd;
                end
                state_next = q_empty ? ST_IDLE : ST_POPWAIT;
            end
            ST_POPWAIT:
                state_next = ST_CHECK;
            ST_CHECK:
            begin
                // d_rdata holds the stored distance of the popped cell.
                if ({1'b0, cd_reg} > d_rdata)
                    state_next = ST_POP;
                else
                begin
                    td_next = (k_rdata == KIND_ZERO) ? cd_reg :
                        ((cd_reg == DIST_W'(DIST_MAX)) ? cd_reg : cd_reg + 1'b1);
                    nbr_next = '0;
                    state_next = ST_NBR;
                end
            end
            ST_NBR:
            begin
                tx_next = ntx[SIDE_W-1:0];
                ty_next = nty[SIDE_W-1:0];
                if (n_in) state_next = ST_NBRWAIT;
                else if (nbr_reg == 4'd7) state_next = ST_POP;
                else nbr_next = nbr_reg + 1'b1;
            end
            ST_NBRWAIT:
                state_next = ST_RELAX;
            ST_RELAX:
            begin
                if (nbr_reg == 4'd7) state_next = ST_POP;
                else
                begin
                    nbr_next = nbr_reg + 1'b1;
                    state_next = ST_NBR;
                end
            end
            ST_READWAIT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    logic improve;
    assign improve = (k_rdata[1] == 1'b0) && ({1'b0, td_reg} < d_rdata);

    always_comb
    begin
        k_we = 1'b0; k_waddr = {request.cell_y, request.cell_x}; k_wdata = request.cell_kind;
        k_raddr = {hy, hx};
        d_we = 1'b0; d_waddr = clr_reg; d_wdata = {1'b1, DIST_W'(0)};
        d_raddr = {hy, hx};
        q_clear = 1'b0; q_pf = 1'b0; q_pb = 1'b0; q_pop = 1'b0;
        out_valid_next = 1'b0;
        out_next = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                d_raddr = {request.cell_y, request.cell_x};
                if (accept && op_t'(request.operation) == OP_LOAD) k_we = 1'b1;
            end
            ST_CLEAR:
            begin
                d_we = 1'b1;
                q_clear = 1'b1;
                if (clr_reg == CELL_W'(CELLS - 1) && ({1'b0, cx_reg} < w_eff)
                    && ({1'b0, cy_reg} < h_eff))
                    q_pb = 1'b1;
            end
            ST_POP:
                q_pop = !q_empty;
            ST_POPWAIT:
            begin
                // Read again once the source write after the clear pass has landed.
                k_raddr = {cy_reg, cx_reg};
                d_raddr = {cy_reg, cx_reg};
            end
            ST_NBR:
            begin
                k_raddr = {nty[SIDE_W-1:0], ntx[SIDE_W-1:0]};
                d_raddr = {nty[SIDE_W-1:0], ntx[SIDE_W-1:0]};
            end
            ST_NBRWAIT:
            begin
                k_raddr = {ty_reg, tx_reg};
                d_raddr = {ty_reg, tx_reg};
            end
            ST_RELAX:
            begin
                if (improve)
                begin
                    d_we    = 1'b1;
                    d_waddr = {ty_reg, tx_reg};
                    d_wdata = {1'b0, td_reg};
                    q_pf    = (td_reg == cd_reg);
                    q_pb    = (td_reg != cd_reg);
                end
            end
            ST_READWAIT:
            begin
                out_valid_next = 1'b1;
                if (searched_reg && ({1'b0, rx_reg} < w_eff) && ({1'b0, ry_reg} < h_eff)
                    && !d_rdata[DIST_W])
                begin
                    out_next.distance  = d_rdata[DIST_W-1:0];
                    out_next.reachable = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Source write: a second write after the clear pass ends.
    logic src_we_reg;
    logic              d_we_m;
    logic [CELL_W-1:0] d_waddr_m;
    logic [DIST_W:0]   d_wdata_m;
    always_comb
    begin
        d_we_m = d_we; d_waddr_m = d_waddr; d_wdata_m = d_wdata;
        if (src_we_reg)
        begin
            d_we_m = 1'b1; d_waddr_m = {cy_reg, cx_reg}; d_wdata_m = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            width_reg    <= 7'd64;
            height_reg   <= 7'd64;
            result_valid <= 1'b0;
            src_we_reg   <= 1'b0;
            searched_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= out_valid_next;
            src_we_reg   <= (state_reg == ST_CLEAR) && q_pb;
            if (accept && op_t'(request.operation) == OP_RUN)
            begin
                searched_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        clr_reg <= clr_next;
        cx_reg <= cx_next; cy_reg <= cy_next; cd_reg <= cd_next; td_reg <= td_next;
        nbr_reg <= nbr_next; tx_reg <= tx_next; ty_reg <= ty_next;
        result <= out_next;
        if (accept)
        begin
            rx_reg <= request.cell_x;
            ry_reg <= request.cell_y;
        end
    end

    gzosp_ram #(.WIDTH(2), .DEPTH(CELLS)) u_kind (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(k_raddr), .rdata(k_rdata)
    );

    gzosp_ram #(.WIDTH(DIST_W+1), .DEPTH(CELLS)) u_dist (
        .clk(clk), .we(d_we_m), .waddr(d_waddr_m), .wdata(d_wdata_m),
        .raddr(d_raddr), .rdata(d_rdata)
    );

    gzosp_deque u_deque (
        .clk(clk), .rst_n(rst_n), .clear(q_clear && !q_pb), .put_front(q_pf),
        .put_back(q_pb), .push_data(state_reg == ST_CLEAR ?
            {cx_reg, cy_reg, DIST_W'(0)} : {tx_reg, ty_reg, td_reg}),
        .pop(q_pop), .head_data(q_head), .empty(q_empty)
    );
endmodule

/* design/gzosp_checker.sv */
// Port-level checker for the shortest-path engine, bound to the top level.
module gzosp_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input gzosp_pkg::req_t request,
    input logic            busy,
    input logic            result_valid,
    input gzosp_pkg::rsp_t result
);
    import gzosp_pkg::*;

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.operation == OP_READ |=> busy)
        else $error("read request did not occupy the engine");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.operation == OP_READ |=> ##1 result_valid)
        else $error("read result missing");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.operation == OP_LOAD |=> !busy)
        else $error("load produced activity");

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.reachable |-> result.distance == '0)
        else $error("unreachable cell with nonzero distance");
endmodule

bind grid_zero_one_shortest_path_top gzosp_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .request(request), .busy(busy),
    .result_valid(result_valid), .result(result)
);

/* tb/tb.sv */
// Testbench for the grid 0-1 shortest-path engine: random grids, searches and distance reads.
module tb;
    import gzosp_pkg::*;

    localparam logic [1:0] KIND_BLOCKED = 2'd2;
    localparam logic [1:0] KIND_THREE   = 2'd3;
    localparam int         UNREACHED    = 13'h1000;

    typedef struct {
        int x;
        int y;
        int d;
    } work_t;

    class path_scoreboard;
        logic [1:0]  kinds[CELLS];
        logic [12:0] dists[CELLS];
        int          width_reg;
        int          height_reg;
        rsp_t        reads_due[$];
        int          errors;

        function new();
            foreach (kinds[i]) kinds[i] = KIND_ZERO;
            foreach (dists[i]) dists[i] = UNREACHED;
            width_reg  = 64;
            height_reg = 64;
            errors     = 0;
        endfunction

        function int clamp_side(int v);
            if (v == 0) return 1;
            if (v > MAX_SIDE) return MAX_SIDE;
            return v;
        endfunction

        function void search_from(int sx, int sy);
            work_t wq[$];
            work_t e;
            int w;
            int h;
            int td;
            int tx;
            int ty;
            int t;
            w = clamp_side(width_reg);
            h = clamp_side(height_reg);
            foreach (dists[i]) dists[i] = UNREACHED;
            if (sx >= w || sy >= h) return;
            dists[sy * MAX_SIDE + sx] = 0;
            wq.insert(wq.size(), work_t'{sx, sy, 0});
            while (wq.size() > 0) begin
                e = wq[0];
                wq.delete(0);
                // Entries superseded by a shorter offer are skipped.
                if (e.d > dists[e.y * MAX_SIDE + e.x]) continue;
                td = e.d + ((kinds[e.y * MAX_SIDE + e.x] == KIND_ZERO) ? 0 : 1);
                if (td > DIST_MAX) td = DIST_MAX;
                for (int dx = -1; dx <= 1; dx++) begin
                    for (int dy = -1; dy <= 1; dy++) begin
                        tx = e.x + dx;
                        ty = e.y + dy;
                        if (tx < 0 || ty < 0 || tx >= w || ty >= h) continue;
                        t = ty * MAX_SIDE + tx;
                        if (kinds[t] >= KIND_BLOCKED) continue;
                        if (td < dists[t]) begin
                            if (wq.size() < DEQUE_DEPTH) begin
                                if (td == e.d) wq.insert(0, work_t'{tx, ty, td});
                                else wq.insert(wq.size(), work_t'{tx, ty, td});
                            end
                            dists[t] = td;
                        end
                    end
                end
            end
        endfunction

        function void note_request(req_t r);
            rsp_t exp_rsp;
            case (op_t'(r.operation))
                OP_LOAD: kinds[r.cell_y * MAX_SIDE + r.cell_x] = r.cell_kind;
                OP_RUN:  search_from(r.cell_x, r.cell_y);
                OP_READ:
                begin
                    exp_rsp = '0;
                    if (r.cell_x < clamp_side(width_reg) && r.cell_y < clamp_side(height_reg)
                        && dists[r.cell_y * MAX_SIDE + r.cell_x] < UNREACHED) begin
                        exp_rsp.distance  = dists[r.cell_y * MAX_SIDE + r.cell_x][11:0];
                        exp_rsp.reachable = 1'b1;
                    end
                    reads_due.insert(reads_due.size(), exp_rsp);
                end
                default: ;
            endcase
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp_rsp;
            if (reads_due.size() == 0) begin
                $display("%0t: unexpected read result distance=%0d reachable=%0b",
                         $time, got.distance, got.reachable);
                errors++;
                return;
            end
            exp_rsp = reads_due[0];
            reads_due.delete(0);
            if (got.distance !== exp_rsp.distance) begin
                $display("%0t: distance mismatch expected %0d actual %0d",
                         $time, exp_rsp.distance, got.distance);
                errors++;
            end
            if (got.reachable !== exp_rsp.reachable) begin
                $display("%0t: reachable mismatch expected %0b actual %0b",
                         $time, exp_rsp.reachable, got.reachable);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    req_t       request;
    logic       busy;
    logic       result_valid;
    rsp_t       result;
    logic       cfg_we;
    logic       cfg_index;
    logic [6:0] cfg_data;

    path_scoreboard sb;
    bit             written[CELLS];

    grid_zero_one_shortest_path_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid) sb.check_result(result);
    end

    task automatic send(input logic [1:0] op, input int x, input int y, input logic [1:0] kind);
        req_t r;
        r.operation = op;
        r.cell_x    = x[5:0];
        r.cell_y    = y[5:0];
        r.cell_kind = kind;
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(r);
        if (op == OP_LOAD) written[y * MAX_SIDE + x] = 1'b1;
    endtask

    task automatic pause();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return;
        start <= 1'b0;
        if (p < 90) repeat ($urandom_range(1, 3)) @(posedge clk);
        else repeat ($urandom_range(10, 40)) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (busy || sb.reads_due.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // The caller drops cfg_we after its last write.
    task automatic write_reg(input logic idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[6:0];
        @(posedge clk);
        if (idx == REG_WIDTH) sb.width_reg = value;
        else sb.height_reg = value;
    endtask

    function automatic logic [1:0] random_kind();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return KIND_ZERO;
        if (p < 80) return KIND_UNIT;
        if (p < 95) return KIND_BLOCKED;
        return KIND_THREE;
    endfunction

    int widths[7]  = '{1, 0, 2, 5, 1, 4, 3};
    int heights[7] = '{1, 0, 3, 1, 6, 4, 2};

    initial
    begin
        int w;
        int h;
        int sx;
        int sy;
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reads before any search see every cell unreached; operation 3 is a no-op.
        send(OP_READ, 0, 0, KIND_ZERO);
        send(OP_NONE, 63, 63, KIND_THREE);
        send(OP_READ, 63, 63, KIND_ZERO);
        drain();

        for (int p = 0; p < 7; p++) begin
            write_reg(REG_WIDTH, widths[p]);
            write_reg(REG_HEIGHT, heights[p]);
            cfg_we <= 1'b0;
            w = sb.clamp_side(widths[p]);
            h = sb.clamp_side(heights[p]);
            // Every cell a search can touch must hold a loaded kind.
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                    if (!written[y * MAX_SIDE + x]) begin
                        send(OP_LOAD, x, y, random_kind());
                        pause();
                    end
            // Loads outside the grid in use are still stored.
            send(OP_LOAD, 63, $urandom_range(0, 63), random_kind());
            if (p == 5) send(OP_LOAD, 0, 0, KIND_BLOCKED);
            for (int k = 0; k < 2; k++) begin
                send(OP_LOAD, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                     random_kind());
                pause();
                sx = $urandom_range(0, w - 1);
                sy = $urandom_range(0, h - 1);
                if (p == 5 && k == 0) begin
                    sx = 0;
                    sy = 0;
                end
                else if ($urandom_range(0, 9) == 0) begin
                    sx = $urandom_range(0, 63);
                    sy = $urandom_range(0, 63);
                end
                send(OP_RUN, sx, sy, random_kind());
                pause();
                repeat (3) begin
                    if ($urandom_range(0, 7) == 0)
                        send(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63), KIND_ZERO);
                    else
                        send(OP_READ, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                             random_kind());
                    pause();
                end
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.reads_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #80000000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
design/gzosp_pkg.sv
design/gzosp_ram.sv
design/gzosp_deque.sv
design/grid_zero_one_shortest_path_top.sv
design/gzosp_checker.sv
tb/tb.sv
